// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define PCPG_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define PCPG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define PCPG_ASSERT_ALWAYS(lbl, clk, rst, expr)

`define PCPG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/pcpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Plain changes permutation generator package
// Widths, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpg_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int ELEM_W       = 5;
   localparam int COUNT_W      = 45;
   localparam int STEP_W       = 3;
   localparam int ADDR_W       = 3;
   localparam int DATA_W       = 32;

   localparam logic [ELEM_W-1:0] RESET_COUNT = 5'd4;

   // Register indexes (paddr[2] selects the word).
   localparam logic REG_ELEMENT_COUNT = 1'b0;

   // Sequencer program step addresses.
   localparam logic [STEP_W-1:0] STEP_ACCEPT  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_FETCH   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_PROBE   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_SWAPA   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_SWAPB   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT    = 3'd5;
   localparam logic [STEP_W-1:0] STEP_COMMIT  = 3'd6;
   localparam logic [STEP_W-1:0] STEP_COMMIT2 = 3'd7;

   typedef enum logic [2:0] {
      OP_ACCEPT  = 3'd0,
      OP_FETCH   = 3'd1,
      OP_PROBE   = 3'd2,
      OP_SWAPA   = 3'd3,
      OP_SWAPB   = 3'd4,
      OP_EMIT    = 3'd5,
      OP_COMMIT  = 3'd6,
      OP_COMMIT2 = 3'd7
   } op_type;

   // Jump condition: when it is true the sequencer goes to the target step,
   // otherwise it falls through to the next one.
   typedef enum logic [2:0] {
      F_NEVER    = 3'd0,
      F_ALWAYS   = 3'd1,
      F_NOACC    = 3'd2,
      F_MLOW     = 3'd3,
      F_BLOCKED  = 3'd4,
      F_EMITHOLD = 3'd5,
      F_FIN      = 3'd6
   } flag_type;

   typedef struct packed {
      op_type             op;
      flag_type           flag;
      logic [STEP_W-1:0]  target;
   } ctl_type;

   function automatic ctl_type ucode(input logic [STEP_W-1:0] step);
      ctl_type w;
      case (step)
         STEP_ACCEPT:  w = '{op: OP_ACCEPT,  flag: F_NOACC,    target: STEP_ACCEPT};
         STEP_FETCH:   w = '{op: OP_FETCH,   flag: F_MLOW,     target: STEP_EMIT};
         STEP_PROBE:   w = '{op: OP_PROBE,   flag: F_BLOCKED,  target: STEP_FETCH};
         STEP_SWAPA:   w = '{op: OP_SWAPA,   flag: F_NEVER,    target: STEP_ACCEPT};
         STEP_SWAPB:   w = '{op: OP_SWAPB,   flag: F_NEVER,    target: STEP_ACCEPT};
         STEP_EMIT:    w = '{op: OP_EMIT,    flag: F_EMITHOLD, target: STEP_EMIT};
         STEP_COMMIT:  w = '{op: OP_COMMIT,  flag: F_FIN,      target: STEP_ACCEPT};
         STEP_COMMIT2: w = '{op: OP_COMMIT2, flag: F_ALWAYS,   target: STEP_ACCEPT};
         default:      w = '{op: OP_ACCEPT,  flag: F_ALWAYS,   target: STEP_ACCEPT};
      endcase
      return w;
   endfunction

   // Out-of-range counts act as the nearest legal one.
   function automatic logic [ELEM_W-1:0] clamp_count(input logic [ELEM_W-1:0] c);
      logic [ELEM_W-1:0] r;
      if (c == '0) begin
         r = ELEM_W'(1);
      end else if (c > ELEM_W'(MAX_ELEMENTS)) begin
         r = ELEM_W'(MAX_ELEMENTS);
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/plain_changes_permutation_gen.sv =====
// ----------------------------------------------------------------------------
// Plain changes permutation generator
// Lists all permutations of 1..n by swaps of neighbours (Johnson-Trotter).
// ----------------------------------------------------------------------------
// Each request word makes the block send the current permutation as n
// response words, one per element in element order, each giving that
// element's position; the last word carries last_in_run, and every word of
// the last of the n! permutations carries final_permutation, after which the
// block starts over from the identity. A request with restart set reloads the
// identity first. Writing element_count (byte address 0) also reloads it. An
// item is accepted, then each element examined in the search for the largest
// mobile element is read in a fetch and a probe step, the swap runs in the
// SWAPA and SWAPB steps, the words are sent (held while the response side
// stalls) and the COMMIT and COMMIT2 steps finish it. The last permutation
// skips the swap and finishes in the COMMIT step, which reloads the identity;
// a short microcode program steps through the state tables, which are read
// at one address per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module plain_changes_permutation_gen (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pcpg_pkg::ELEM_W-1:0]    rsp_element_index,
   output logic [pcpg_pkg::ELEM_W-1:0]    rsp_element_position,
   output logic                           rsp_last_in_run,
   output logic                           rsp_final_permutation,
   output logic [pcpg_pkg::COUNT_W-1:0]   rsp_perm_number,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pcpg_pkg::ADDR_W-1:0]    paddr,
   input  logic [pcpg_pkg::DATA_W-1:0]    pwdata,
   output logic [pcpg_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);
   import pcpg_pkg::*;

   localparam int POS_DEPTH = MAX_ELEMENTS + 2;

   // State tables. Direction is two's complement: -1 left, +1 right, 0 none.
   logic [ELEM_W-1:0]  pos_ff [1:MAX_ELEMENTS];
   logic [ELEM_W-1:0]  ea_ff  [0:POS_DEPTH-1];
   logic [1:0]         dir_ff [1:MAX_ELEMENTS];

   logic [ELEM_W-1:0]  cnt_ff;
   logic [STEP_W-1:0]  upc_ff, upc_in;
   logic [ELEM_W-1:0]  m_ff, m_in;
   logic [ELEM_W-1:0]  idx_ff, idx_in;
   logic [ELEM_W-1:0]  pm_ff, pm_in;
   logic [ELEM_W-1:0]  nb_ff, nb_in;
   logic [ELEM_W-1:0]  other_ff, other_in;
   logic               fin_ff, fin_in;
   logic [COUNT_W-1:0] perm_ff, perm_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]  rsp_index_ff, rsp_pos_ff;
   logic               rsp_last_ff, rsp_final_ff;
   logic [COUNT_W-1:0] rsp_num_ff;

   ctl_type            ctl;
   logic [ELEM_W-1:0]  n_act;
   logic               cfg_wr;
   logic               req_acc;
   logic               out_free;
   logic               take;
   logic               load_id;
   logic [ELEM_W-1:0]  load_n;
   logic [ELEM_W-1:0]  pos_addr;
   logic [ELEM_W-1:0]  pos_rd;
   logic [1:0]         dir_rd;
   logic [ELEM_W-1:0]  ea_rd;
   logic               blocked;
   logic               emit;

   assign ctl      = ucode(upc_ff);
   assign n_act    = clamp_count(cnt_ff);
   assign pready   = 1'b1;
   assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_ELEMENT_COUNT);
   assign prdata   = (paddr[2] == REG_ELEMENT_COUNT) ? {{(DATA_W-ELEM_W){1'b0}}, cnt_ff} : '0;

   assign req_stall = (ctl.op != OP_ACCEPT);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (ctl.op == OP_EMIT) && out_free;

   // One read port per table.
   assign pos_addr = (ctl.op == OP_EMIT) ? idx_ff : m_ff;
   assign pos_rd   = pos_ff[pos_addr];
   assign dir_rd   = dir_ff[m_ff];
   assign ea_rd    = ea_ff[nb_ff];
   assign blocked  = (ea_rd > m_ff);

   // The identity is reloaded on reset, on a count write, on a restart
   // request and after the last permutation has been sent.
   always_comb begin
      load_id = reset || cfg_wr
              || ((ctl.op == OP_ACCEPT) && req_acc && req_restart)
              || ((ctl.op == OP_COMMIT) && fin_ff);
      if (reset) begin
         load_n = RESET_COUNT;
      end else if (cfg_wr) begin
         load_n = clamp_count(pwdata[ELEM_W-1:0]);
      end else begin
         load_n = n_act;
      end
   end

   // Sequencer.
   always_comb begin
      case (ctl.flag)
         F_NEVER:    take = 1'b0;
         F_ALWAYS:   take = 1'b1;
         F_NOACC:    take = !req_acc;
         F_MLOW:     take = (m_ff <= ELEM_W'(1));
         F_BLOCKED:  take = blocked;
         F_EMITHOLD: take = !(out_free && (idx_ff == n_act));
         F_FIN:      take = fin_ff;
         default:    take = 1'b1;
      endcase
      upc_in = take ? ctl.target : upc_ff + STEP_W'(1);
   end

   // Datapath registers driven by the control word.
   always_comb begin
      m_in     = m_ff;
      idx_in   = idx_ff;
      pm_in    = pm_ff;
      nb_in    = nb_ff;
      other_in = other_ff;
      fin_in   = fin_ff;
      perm_in  = perm_ff;
      case (ctl.op)
         OP_ACCEPT: begin
            if (req_acc) begin
               m_in   = n_act;
               idx_in = ELEM_W'(1);
            end
         end
         OP_FETCH: begin
            fin_in = (m_ff <= ELEM_W'(1));
            pm_in  = pos_rd;
            nb_in  = pos_rd + {{(ELEM_W-2){dir_rd[1]}}, dir_rd};
         end
         OP_PROBE: begin
            if (blocked) begin
               m_in = m_ff - ELEM_W'(1);
            end else begin
               other_in = ea_rd;
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               idx_in = idx_ff + ELEM_W'(1);
            end
         end
         OP_COMMIT2: begin
            perm_in = perm_ff + COUNT_W'(1);
         end
         default: begin
         end
      endcase
      if (load_id) begin
         perm_in = '0;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= STEP_ACCEPT;
         cnt_ff       <= RESET_COUNT;
         m_ff         <= ELEM_W'(1);
         idx_ff       <= ELEM_W'(1);
         fin_ff       <= 1'b0;
         perm_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         m_ff         <= m_in;
         idx_ff       <= idx_in;
         fin_ff       <= fin_in;
         perm_ff      <= perm_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) begin
            cnt_ff <= pwdata[ELEM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      pm_ff    <= pm_in;
      nb_ff    <= nb_in;
      other_ff <= other_in;
      if (emit) begin
         rsp_index_ff <= idx_ff;
         rsp_pos_ff   <= pos_rd;
         rsp_last_ff  <= (idx_ff == n_act);
         rsp_final_ff <= fin_ff;
         rsp_num_ff   <= perm_ff;
      end
   end

   // State tables: one write per table per cycle, or a full identity load.
   always_ff @(posedge clock) begin
      if (load_id) begin
         for (int i = 1; i <= MAX_ELEMENTS; i++) begin
            pos_ff[i] <= ELEM_W'(i);
            dir_ff[i] <= (i == 1) ? 2'b00 : 2'b11;
         end
         for (int j = 0; j < POS_DEPTH; j++) begin
            if (j == 0 || j == int'(load_n) + 1) begin
               ea_ff[j] <= load_n + ELEM_W'(1);
            end else begin
               ea_ff[j] <= ELEM_W'(j);
            end
         end
      end else begin
         case (ctl.op)
            OP_PROBE: begin
               if (blocked) begin
                  dir_ff[m_ff] <= ~dir_rd + 2'b01;
               end
            end
            OP_SWAPA:   ea_ff[pm_ff]     <= other_ff;
            OP_SWAPB:   ea_ff[nb_ff]     <= m_ff;
            OP_COMMIT:  pos_ff[other_ff] <= pm_ff;
            OP_COMMIT2: pos_ff[m_ff]     <= nb_ff;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_element_index     = rsp_index_ff;
   assign rsp_element_position  = rsp_pos_ff;
   assign rsp_last_in_run       = rsp_last_ff;
   assign rsp_final_permutation = rsp_final_ff;
   assign rsp_perm_number       = rsp_num_ff;

   // The element scan never runs past the current count or down to element 1.
   `PCPG_ASSERT_IMPLIES(a_probe_range, clock, reset, upc_ff == STEP_PROBE, (m_ff > ELEM_W'(1)) && (m_ff <= n_act))

   // The word counter stays within the permutation while sending.
   `PCPG_ASSERT_IMPLIES(a_emit_range, clock, reset, upc_ff == STEP_EMIT, (idx_ff >= ELEM_W'(1)) && (idx_ff <= n_act))

   // A word flagged as the end of a run reports the highest element.
   `PCPG_ASSERT_IMPLIES(a_last_index, clock, reset, rsp_valid && rsp_last_in_run, rsp_element_index == n_act)

   // A new response word is only loaded once the previous one has gone.
   `PCPG_ASSERT_IMPLIES(a_no_overwrite, clock, reset, rsp_valid && rsp_stall, ##1 rsp_valid && $stable(rsp_element_index))

endmodule

`default_nettype wire
